>>> hdl/lwrt_pkg.sv
// Package for the LRU way replacement tracker: sizes, action and error codes,
// the per-line entry layout and saturating increment helpers.
// No dependencies.
`default_nettype none

package lwrt_pkg;

  localparam int NUM_LINES = 256;
  localparam int IDX_W     = $clog2(NUM_LINES);
  localparam int LCNT_W    = 9;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int ACT_W     = 3;
  localparam int ERR_W     = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_FILL   = 3'd0,
    ACT_TOUCH  = 3'd1,
    ACT_MARK   = 3'd2,
    ACT_VICTIM = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE         = 2'd0,
    ERR_BAD_INDEX    = 2'd1,
    ERR_INVALID_LINE = 2'd2
  } error_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [COUNT_W-1:0] cnt_sat_inc(input logic [COUNT_W-1:0] v);
    return (&v) ? v : v + COUNT_W'(1);
  endfunction

  function automatic logic [STAMP_W-1:0] stamp_sat_inc(input logic [STAMP_W-1:0] v);
    return (&v) ? v : v + STAMP_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/lwrt_ifs.sv
// Channel interfaces of the LRU way replacement tracker: input item,
// result item and configuration write. Depends on lwrt_pkg.
`default_nettype none

interface lwrt_in_if;
  logic                     valid;
  logic                     ready;
  logic [lwrt_pkg::ACT_W-1:0]  action;
  logic [lwrt_pkg::IDX_W-1:0]  way;
  logic [lwrt_pkg::IDX_W-1:0]  range_start;
  logic [lwrt_pkg::LCNT_W-1:0] range_end;
  modport source (output valid, action, way, range_start, range_end, input ready);
  modport sink   (input valid, action, way, range_start, range_end, output ready);
endinterface

interface lwrt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        line_valid;
  logic                        line_dirty;
  logic [lwrt_pkg::IDX_W-1:0]   victim;
  logic [lwrt_pkg::COUNT_W-1:0] hit_count;
  logic [lwrt_pkg::COUNT_W-1:0] miss_count;
  logic [lwrt_pkg::COUNT_W-1:0] writeback_count;
  logic [lwrt_pkg::ERR_W-1:0]   error;
  modport source (output valid, line_valid, line_dirty, victim, hit_count, miss_count,
                  writeback_count, error, input ready);
  modport sink   (input valid, line_valid, line_dirty, victim, hit_count, miss_count,
                  writeback_count, error, output ready);
endinterface

interface lwrt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lwrt_pkg::LCNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/lru_way_replacement_tracker.sv
// Top level of the LRU way replacement tracker: line table in one RAM,
// sequencer for read-modify-write and victim search. Depends on lwrt_pkg,
// lwrt_ifs and lwrt_ram.
//
// in_chan takes one item (action, way, range_start, range_end) when valid and
//   ready are both high; ready is high only while the sequencer is idle.
// out_chan returns one result item per input item, in order, from an output
//   register; the next input item is taken while a result still waits there.
// cfg_chan sets ways_in_use, always ready; write only while idle, unchecked.
// Fill, touch, mark_dirty and query read the line at the accept edge, then
//   modify and write it back (query, and touch of an invalid line, write
//   nothing), then move the result out; an item with a bad index or range
//   goes straight to the move out; find_victim compares one line per cycle,
//   stopping at the first invalid line or at the last line of the range.
// Ready returns only after the move out, so one item is in work at a time.
// Reset: counters clear, the use clock starts at 1, ways_in_use goes to 256;
//   a per-line written bit makes every line read as invalid, clean, stamp 0.
// Stall: while out_chan.ready is low the result holds, and a finished next
//   result waits in the sequencer, so in_chan stays not ready.
`default_nettype none

module lru_way_replacement_tracker (
  input  logic             clk,
  input  logic             rst_n,
  lwrt_cfg_if.sink         cfg_chan,
  lwrt_in_if.sink          in_chan,
  lwrt_out_if.source       out_chan
);
  import lwrt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RMW    = 4'b0010,
    ST_SEARCH = 4'b0100,
    ST_DONE   = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [LCNT_W-1:0]    ways_r;
  action_t              act_r, act_nxt;
  logic [IDX_W-1:0]     way_r, way_nxt;
  logic [LCNT_W-1:0]    re_r, re_nxt;
  logic [IDX_W-1:0]     pend_r, pend_nxt;
  logic [LCNT_W-1:0]    issue_r, issue_nxt;
  logic [IDX_W-1:0]     best_r, best_nxt;
  logic [STAMP_W-1:0]   best_stamp_r, best_stamp_nxt;
  logic                 best_dirty_r, best_dirty_nxt;
  logic                 first_r, first_nxt;
  logic [STAMP_W-1:0]   use_clock_r, use_clock_nxt;
  logic [COUNT_W-1:0]   hits_r, hits_nxt;
  logic [COUNT_W-1:0]   misses_r, misses_nxt;
  logic [COUNT_W-1:0]   wbs_r, wbs_nxt;
  logic [NUM_LINES-1:0] written_r, written_nxt;

  // Result waiting to move into the output register.
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_dirty_r, res_dirty_nxt;
  logic [IDX_W-1:0]     res_victim_r, res_victim_nxt;
  error_t               res_err_r, res_err_nxt;

  // Output register.
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_lv_r, out_ld_r;
  logic [IDX_W-1:0]     out_victim_r;
  logic [COUNT_W-1:0]   out_hits_r, out_misses_r, out_wbs_r;
  error_t               out_err_r;
  logic                 out_load;

  // RAM port signals.
  logic                 ram_re, ram_we;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               wr_ent;

  // Decode of the incoming item.
  action_t              in_act;
  logic [LCNT_W-1:0]    lines_eff;
  logic                 way_bad, range_bad;

  // Line under work and its masked contents.
  logic [IDX_W-1:0]     look_idx;
  entry_t               cur_ent;
  logic                 take;
  logic [LCNT_W-1:0]    pend_last;

  lwrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (way_r),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_act    = action_t'(in_chan.action);
  assign lines_eff = (ways_r > LCNT_W'(NUM_LINES)) ? LCNT_W'(NUM_LINES) : ways_r;
  assign way_bad   = {1'b0, in_chan.way} >= lines_eff;
  assign range_bad = (in_chan.range_end <= {1'b0, in_chan.range_start}) ||
                     (in_chan.range_end > lines_eff);

  // A line never written reads as reset: invalid, clean, stamp zero.
  assign look_idx  = (state_r == ST_SEARCH) ? pend_r : way_r;
  assign cur_ent   = written_r[look_idx] ? entry_t'(ram_rdata) : '0;
  assign take      = first_r || (cur_ent.stamp < best_stamp_r);
  assign pend_last = {1'b0, pend_r} + LCNT_W'(1);

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_load       = (state_r == ST_DONE) && (!out_vld_r || out_chan.ready);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    way_nxt        = way_r;
    re_nxt         = re_r;
    pend_nxt       = pend_r;
    issue_nxt      = issue_r;
    best_nxt       = best_r;
    best_stamp_nxt = best_stamp_r;
    best_dirty_nxt = best_dirty_r;
    first_nxt      = first_r;
    use_clock_nxt  = use_clock_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    wbs_nxt        = wbs_r;
    written_nxt    = written_r;
    res_valid_nxt  = res_valid_r;
    res_dirty_nxt  = res_dirty_r;
    res_victim_nxt = res_victim_r;
    res_err_nxt    = res_err_r;
    ram_re         = 1'b0;
    ram_raddr      = in_chan.way;
    ram_we         = 1'b0;
    wr_ent         = cur_ent;

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          act_nxt        = in_act;
          way_nxt        = in_chan.way;
          re_nxt         = in_chan.range_end;
          res_valid_nxt  = 1'b0;
          res_dirty_nxt  = 1'b0;
          res_victim_nxt = '0;
          res_err_nxt    = ERR_NONE;
          if (in_act == ACT_VICTIM) begin
            if (range_bad) begin
              res_err_nxt = ERR_BAD_INDEX;
              state_nxt   = ST_DONE;
            end else begin
              // Start the scan: first line read now, next address queued.
              ram_re    = 1'b1;
              ram_raddr = in_chan.range_start;
              pend_nxt  = in_chan.range_start;
              issue_nxt = {1'b0, in_chan.range_start} + LCNT_W'(1);
              first_nxt = 1'b1;
              state_nxt = ST_SEARCH;
            end
          end else if (way_bad) begin
            res_err_nxt = ERR_BAD_INDEX;
            state_nxt   = ST_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_chan.way;
            state_nxt = ST_RMW;
          end
        end
      end

      ST_RMW: begin
        case (act_r)
          ACT_FILL: begin
            misses_nxt = cnt_sat_inc(misses_r);
            if (cur_ent.valid && cur_ent.dirty) begin
              wbs_nxt = cnt_sat_inc(wbs_r);
            end
            wr_ent.valid = 1'b1;
            wr_ent.dirty = 1'b0;
            ram_we       = 1'b1;
          end
          ACT_TOUCH: begin
            if (!cur_ent.valid) begin
              res_err_nxt = ERR_INVALID_LINE;
            end else begin
              hits_nxt      = cnt_sat_inc(hits_r);
              wr_ent.stamp  = use_clock_r;
              use_clock_nxt = stamp_sat_inc(use_clock_r);
              ram_we        = 1'b1;
            end
          end
          ACT_MARK: begin
            wr_ent.dirty = 1'b1;
            ram_we       = 1'b1;
          end
          default: begin
            // Query and the unused codes leave the line alone.
          end
        endcase
        if (ram_we) begin
          written_nxt[way_r] = 1'b1;
        end
        res_valid_nxt = wr_ent.valid;
        res_dirty_nxt = wr_ent.dirty;
        state_nxt     = ST_DONE;
      end

      ST_SEARCH: begin
        if (!cur_ent.valid) begin
          // First invalid line wins outright.
          res_valid_nxt  = 1'b0;
          res_dirty_nxt  = cur_ent.dirty;
          res_victim_nxt = pend_r;
          state_nxt      = ST_DONE;
        end else begin
          first_nxt = 1'b0;
          if (take) begin
            best_nxt       = pend_r;
            best_stamp_nxt = cur_ent.stamp;
            best_dirty_nxt = cur_ent.dirty;
          end
          if (pend_last == re_r) begin
            res_valid_nxt  = 1'b1;
            res_dirty_nxt  = take ? cur_ent.dirty : best_dirty_r;
            res_victim_nxt = take ? pend_r : best_r;
            state_nxt      = ST_DONE;
          end else begin
            // Advance: read the next line while this one is compared.
            ram_re    = 1'b1;
            ram_raddr = issue_r[IDX_W-1:0];
            pend_nxt  = issue_r[IDX_W-1:0];
            issue_nxt = issue_r + LCNT_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_vld_nxt = out_load ? 1'b1 : (out_vld_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ways_r       <= LCNT_W'(NUM_LINES);
      use_clock_r  <= STAMP_W'(1);
      hits_r       <= '0;
      misses_r     <= '0;
      wbs_r        <= '0;
      written_r    <= '0;
      out_vld_r    <= 1'b0;
      out_lv_r     <= 1'b0;
      out_ld_r     <= 1'b0;
      out_victim_r <= '0;
      out_hits_r   <= '0;
      out_misses_r <= '0;
      out_wbs_r    <= '0;
      out_err_r    <= ERR_NONE;
    end else begin
      state_r     <= state_nxt;
      use_clock_r <= use_clock_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      wbs_r       <= wbs_nxt;
      written_r   <= written_nxt;
      out_vld_r   <= out_vld_nxt;
      if (cfg_chan.valid) begin
        ways_r <= cfg_chan.data;
      end
      if (out_load) begin
        out_lv_r     <= res_valid_r;
        out_ld_r     <= res_dirty_r;
        out_victim_r <= res_victim_r;
        out_hits_r   <= hits_r;
        out_misses_r <= misses_r;
        out_wbs_r    <= wbs_r;
        out_err_r    <= res_err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    way_r        <= way_nxt;
    re_r         <= re_nxt;
    pend_r       <= pend_nxt;
    issue_r      <= issue_nxt;
    best_r       <= best_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_dirty_r <= best_dirty_nxt;
    first_r      <= first_nxt;
    res_valid_r  <= res_valid_nxt;
    res_dirty_r  <= res_dirty_nxt;
    res_victim_r <= res_victim_nxt;
    res_err_r    <= res_err_nxt;
  end

  assign out_chan.valid           = out_vld_r;
  assign out_chan.line_valid      = out_lv_r;
  assign out_chan.line_dirty      = out_ld_r;
  assign out_chan.victim          = out_victim_r;
  assign out_chan.hit_count       = out_hits_r;
  assign out_chan.miss_count      = out_misses_r;
  assign out_chan.writeback_count = out_wbs_r;
  assign out_chan.error           = out_err_r;

endmodule

`default_nettype wire

>>> hdl/lwrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lwrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/lwrt_checker.sv
// Port-level checker for the LRU way replacement tracker, attached by bind.
// Depends on lwrt_pkg and lru_way_replacement_tracker.
`default_nettype none

module lwrt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_line_valid,
  input logic [lwrt_pkg::IDX_W-1:0]    out_victim,
  input logic [lwrt_pkg::COUNT_W-1:0]  out_miss_count,
  input logic [lwrt_pkg::ERR_W-1:0]    out_error
);
  import lwrt_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim) && $stable(out_error))
    else $error("result changed while stalled");

  // One item at a time: taking an item drops ready.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  // Misses only grow.
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> out_miss_count >= $past(out_miss_count))
    else $error("miss count went down");

  // A failed item shows an invalid line and no victim.
  a_err_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error != ERR_NONE) |-> !out_line_valid && (out_victim == '0))
    else $error("failed item carries line or victim");

  // No undefined error code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error == ERR_NONE) || (out_error == ERR_BAD_INDEX) ||
                  (out_error == ERR_INVALID_LINE))
    else $error("undefined error code");

endmodule

bind lru_way_replacement_tracker lwrt_checker u_lwrt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_line_valid (out_chan.line_valid),
  .out_victim     (out_chan.victim),
  .out_miss_count (out_chan.miss_count),
  .out_error      (out_chan.error)
);

`default_nettype wire

>>> test/tb_lru_way_replacement_tracker.sv
`timescale 1ns / 100ps
// Testbench for lru_way_replacement_tracker: directed and random cache line
// actions, predicted by a line-table scoreboard. Depends on lwrt_pkg, lwrt_ifs.

module tb_lru_way_replacement_tracker;
  import lwrt_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;   // longest victim search plus margin
  localparam int PHASE_ITEMS  = 210;

  // One input item as it goes over in_chan.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  way;
    logic [IDX_W-1:0]  range_start;
    logic [LCNT_W-1:0] range_end;
  } access_t;

  // One result item as it comes back on out_chan.
  typedef struct packed {
    logic               line_valid;
    logic               line_dirty;
    logic [IDX_W-1:0]   victim;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
    logic [COUNT_W-1:0] writeback_count;
    logic [ERR_W-1:0]   error;
  } outcome_t;

  // Line table mirror: predicts every result from the accepted items in order
  // and checks the results against the oldest prediction.
  class lru_scoreboard;
    bit                 valid_bits[NUM_LINES];
    bit                 dirty_bits[NUM_LINES];
    logic [STAMP_W-1:0] stamps[NUM_LINES];
    logic [STAMP_W-1:0] use_tick;
    logic [COUNT_W-1:0] hits, misses, writebacks;
    logic [LCNT_W-1:0]  ways_limit;
    outcome_t           expected_results[$];
    int                 errors;

    function new();
      foreach (valid_bits[i]) begin
        valid_bits[i] = 1'b0;
        dirty_bits[i] = 1'b0;
        stamps[i]     = '0;
      end
      use_tick   = STAMP_W'(1);
      hits       = '0;
      misses     = '0;
      writebacks = '0;
      ways_limit = 9'd256;
      errors     = 0;
    endfunction

    function void set_ways(logic [LCNT_W-1:0] v);
      ways_limit = v;
    endfunction

    function int pending_count();
      return expected_results.size();
    endfunction

    function outcome_t predict_access(access_t a);
      outcome_t r;
      int       n;
      int       best;
      r = '0;
      n = (ways_limit < NUM_LINES) ? int'(ways_limit) : NUM_LINES;
      if (a.action == ACT_VICTIM) begin
        if (int'(a.range_end) <= int'(a.range_start) || int'(a.range_end) > n) begin
          r.error = ERR_BAD_INDEX;
        end else begin
          // First invalid line wins; else oldest stamp, ties to lowest index.
          best = int'(a.range_start);
          for (int i = int'(a.range_start); i < int'(a.range_end); i++) begin
            if (!valid_bits[i]) begin
              best = i;
              break;
            end
            if (stamps[i] < stamps[best]) best = i;
          end
          r.victim     = IDX_W'(best);
          r.line_valid = valid_bits[best];
          r.line_dirty = dirty_bits[best];
        end
      end else if (int'(a.way) >= n) begin
        r.error = ERR_BAD_INDEX;
      end else begin
        case (a.action)
          ACT_FILL: begin
            if (misses != '1) misses++;
            if (valid_bits[a.way] && dirty_bits[a.way] && writebacks != '1) writebacks++;
            valid_bits[a.way] = 1'b1;
            dirty_bits[a.way] = 1'b0;
          end
          ACT_TOUCH: begin
            if (!valid_bits[a.way]) begin
              r.error = ERR_INVALID_LINE;
            end else begin
              if (hits != '1) hits++;
              stamps[a.way] = use_tick;
              if (use_tick != '1) use_tick++;
            end
          end
          ACT_MARK: dirty_bits[a.way] = 1'b1;
          default: ;   // query and the unused codes change nothing
        endcase
        r.line_valid = valid_bits[a.way];
        r.line_dirty = dirty_bits[a.way];
      end
      r.hit_count       = hits;
      r.miss_count      = misses;
      r.writeback_count = writebacks;
      return r;
    endfunction

    function void note_access(access_t a);
      expected_results.push_back(predict_access(a));
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (errors < 40)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result item with no item outstanding", $time);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      match("line_valid", 32'(want.line_valid), 32'(got.line_valid));
      match("line_dirty", 32'(want.line_dirty), 32'(got.line_dirty));
      match("victim", 32'(want.victim), 32'(got.victim));
      match("hit_count", want.hit_count, got.hit_count);
      match("miss_count", want.miss_count, got.miss_count);
      match("writeback_count", want.writeback_count, got.writeback_count);
      match("error", 32'(want.error), 32'(got.error));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lwrt_cfg_if cfg_if();
  lwrt_in_if  in_if();
  lwrt_out_if out_if();

  lru_way_replacement_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_if),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  lru_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ways_setting  = 256;
  int stall_asked   = 0;   // bumped by the stimulus to ask for a long hold-off
  int stall_taken   = 0;
  int hold_left     = 0;

  // Drive ready on the result side; hold it low in reset and serve a long
  // hold-off when one is asked.
  always @(posedge clk) begin
    if (stall_taken != stall_asked) begin
      stall_taken = stall_asked;
      hold_left   = STALL_CYCLES;
    end
    if (rst_n !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample results on the falling edge before the accepting edge, where the
  // payload and both handshake lines are settled.
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{out_if.line_valid, out_if.line_dirty, out_if.victim,
                        out_if.hit_count, out_if.miss_count, out_if.writeback_count,
                        out_if.error});
  end

  // Offer one item, idling first at the current sender rate; return at the
  // edge that takes it. Valid stays high so a following item goes back to back.
  task automatic send_access(access_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= a.action;
    in_if.way         <= a.way;
    in_if.range_start <= a.range_start;
    in_if.range_end   <= a.range_end;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    sb.note_access(a);
  endtask

  task automatic send_fields(logic [ACT_W-1:0] act, int way, int rs, int re);
    send_access('{act, IDX_W'(way), IDX_W'(rs), LCNT_W'(re)});
  endtask

  // Drop valid and hold the sender until every result has come back.
  task automatic wait_results_done();
    in_if.valid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
  endtask

  // Write ways_in_use; only with the block idle.
  task automatic write_ways(int v);
    wait_results_done();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= LCNT_W'(v);
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_ways(LCNT_W'(v));
    ways_setting = v;
  endtask

  // Mostly well-formed actions on a few hot 16-line sets, so sets fill up and
  // victim searches fall back on stamps; the rest is random noise.
  function automatic access_t random_access(int n);
    access_t a;
    int      sets, hot, base, span, lo, roll;
    a.action      = ACT_W'($urandom_range(7));
    a.way         = IDX_W'($urandom_range(255));
    a.range_start = IDX_W'($urandom_range(255));
    a.range_end   = LCNT_W'($urandom_range(511));
    if (n == 0 || $urandom_range(99) >= 82) return a;
    sets = (n + 15) / 16;
    hot  = (sets < 3) ? sets : 3;
    base = 16 * int'(($urandom_range(99) < 85) ? $urandom_range(hot - 1)
                                                : $urandom_range(sets - 1));
    span = (n - base < 16) ? n - base : 16;
    roll = int'($urandom_range(99));
    if (roll < 70) begin
      a.way = IDX_W'(base + int'($urandom_range(span - 1)));
      if (roll < 24)      a.action = ACT_FILL;
      else if (roll < 54) a.action = ACT_TOUCH;
      else if (roll < 64) a.action = ACT_MARK;
      else                a.action = ACT_QUERY;
    end else begin
      a.action = ACT_VICTIM;
      if ($urandom_range(19) == 0) begin
        a.range_start = '0;
        a.range_end   = LCNT_W'(n);
      end else if ($urandom_range(3) != 0) begin
        a.range_start = IDX_W'(base);
        a.range_end   = LCNT_W'(base + span);
      end else begin
        lo            = int'($urandom_range(span - 1));
        a.range_start = IDX_W'(base + lo);
        a.range_end   = LCNT_W'(base + lo + int'($urandom_range(1, span - lo)));
      end
    end
    return a;
  endfunction

  task automatic run_random(int count);
    int n;
    for (int i = 0; i < count; i++) begin
      n = (ways_setting < NUM_LINES) ? ways_setting : NUM_LINES;
      send_access(random_access(n));
    end
  endtask

  // Abort a hung run.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n             <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.data       <= '0;
    in_if.valid       <= 1'b0;
    in_if.action      <= '0;
    in_if.way         <= '0;
    in_if.range_start <= '0;
    in_if.range_end   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset width of 256 lines.
    send_fields(ACT_TOUCH, 5, 0, 1);          // touch of a line never filled
    send_fields(ACT_MARK, 7, 0, 1);           // dirty bit on an invalid line
    send_fields(ACT_FILL, 7, 0, 1);           // invalid dirty line: no writeback
    send_fields(ACT_FILL, 255, 0, 1);
    send_fields(ACT_MARK, 255, 0, 1);
    send_fields(ACT_FILL, 255, 0, 1);         // valid dirty line: writeback
    send_fields(ACT_TOUCH, 255, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 256);       // whole table, first invalid line
    send_fields(ACT_VICTIM, 0, 255, 256);     // last line alone
    send_fields(ACT_VICTIM, 0, 10, 10);       // empty range
    send_fields(ACT_VICTIM, 0, 200, 100);     // reversed range
    send_fields(ACT_VICTIM, 0, 0, 511);       // end past the table
    send_fields(3'd5, 255, 0, 1);             // unused codes act as query
    send_fields(3'd6, 7, 0, 1);
    send_fields(3'd7, 0, 0, 1);
    send_fields(ACT_FILL, 0, 0, 1);
    send_fields(ACT_FILL, 1, 0, 1);
    send_fields(ACT_FILL, 2, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 3);         // equal stamps, lowest index wins
    send_fields(ACT_TOUCH, 1, 0, 1);
    send_fields(ACT_TOUCH, 0, 0, 1);
    send_fields(ACT_TOUCH, 2, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 3);         // oldest stamp wins

    write_ways(1);                            // a single line
    send_fields(ACT_FILL, 0, 0, 1);
    send_fields(ACT_FILL, 1, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 2);
    write_ways(0);                            // every index out of range
    send_fields(ACT_QUERY, 0, 0, 1);
    send_fields(ACT_VICTIM, 0, 0, 1);

    // Random phase one: slow receiver, small table.
    write_ways(24);
    send_idle_pct = 19;
    recv_idle_pct = 86;
    run_random(PHASE_ITEMS);

    // Random phase two: slow sender, full table; pause midway for a drain.
    write_ways(256);
    send_idle_pct = 86;
    recv_idle_pct = 19;
    run_random(PHASE_ITEMS / 2);
    wait_results_done();
    run_random(PHASE_ITEMS / 2);

    // Random phase three: no idling, width above the table, and one long
    // receiver hold-off so the block backs up into its input.
    write_ways(511);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked <= stall_asked + 1;
    run_random(PHASE_ITEMS);

    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_count() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_count());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
